### hdl/oldest_first_issue_select_top_defines.svh
// assertion macros for the oldest-first issue select block
// expects clk_i and rst_ni in the scope of each use
`ifndef OLDEST_FIRST_ISSUE_SELECT_TOP_DEFINES_SVH
`define OLDEST_FIRST_ISSUE_SELECT_TOP_DEFINES_SVH

// same-cycle implication
`define OFIS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OFIS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ofis_pkg.sv
// shared sizes, codes and inter-module structs of the issue select block
// no dependencies
package ofis_pkg;

  localparam int ENTRIES      = 16;
  localparam int WAYS         = 2;
  localparam int AGE_BITS     = 32;
  localparam int PAYLOAD_BITS = 16;

  localparam int SLOT_BITS = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_SCHED = 1'b1
  } ofis_cmd_e;

  typedef enum logic {
    POLICY_IN_ORDER = 1'b0,
    POLICY_OOO      = 1'b1
  } ofis_policy_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } ofis_state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                    wr_en;
    logic [SLOT_BITS-1:0]    wr_slot;
    logic                    wr_valid;
    logic [AGE_BITS-1:0]     wr_age;
    logic [PAYLOAD_BITS-1:0] wr_payload;
    logic [1:0]              wr_rdy;
    logic                    mark_en;
    logic [SLOT_BITS-1:0]    mark_slot;
    logic                    ooo;
    logic                    ring_load;
  } ofis_cell_ctl_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic                    found;
    logic [SLOT_BITS-1:0]    slot;
    logic [AGE_BITS-1:0]     age;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    rdy_ok;
  } ofis_tok_t;

  // age copy rotating around the row for the duplicate check
  typedef struct packed {
    logic                valid;
    logic [AGE_BITS-1:0] age;
  } ofis_ring_t;

endpackage

### hdl/ofis_cell.sv
// one station entry plus its stage of the oldest-first search chain
// and its stage of the rotating duplicate-age ring; uses ofis_pkg
module ofis_cell
  import ofis_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SLOT_BITS-1:0] cell_idx_i,
  input  ofis_cell_ctl_t       ctl_i,
  input  ofis_tok_t            tok_i,
  output ofis_tok_t            tok_o,
  input  ofis_ring_t           ring_i,
  output ofis_ring_t           ring_o,
  output logic                 hit_o
);

  logic                    valid_q;
  logic                    sched_q;
  logic [1:0]              rdy_q;
  logic [AGE_BITS-1:0]     age_q;
  logic [PAYLOAD_BITS-1:0] payload_q;

  ofis_tok_t  tok_q, tok_d;
  ofis_ring_t ring_q, ring_d;

  logic wr_hit;
  logic eligible;
  logic take;

  assign wr_hit = ctl_i.wr_en && (ctl_i.wr_slot == cell_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sched_q <= 1'b0;
      rdy_q   <= 2'b00;
    end else if (wr_hit) begin
      valid_q <= ctl_i.wr_valid;
      sched_q <= 1'b0;
      rdy_q   <= ctl_i.wr_rdy;
    end else if (ctl_i.mark_en && (ctl_i.mark_slot == cell_idx_i)) begin
      sched_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      age_q     <= ctl_i.wr_age;
      payload_q <= ctl_i.wr_payload;
    end
  end

  // strict compare: on equal ages the lower slot, seen first, stays
  always_comb begin
    eligible = valid_q && !sched_q && (!ctl_i.ooo || (rdy_q == 2'b11));
    take     = eligible && (!tok_i.found || (age_q < tok_i.age));
    tok_d    = tok_i;
    if (take) begin
      tok_d.found   = 1'b1;
      tok_d.slot    = cell_idx_i;
      tok_d.age     = age_q;
      tok_d.payload = payload_q;
      tok_d.rdy_ok  = (rdy_q == 2'b11);
    end
  end

  always_comb begin
    if (ctl_i.ring_load) begin
      ring_d.valid = valid_q;
      ring_d.age   = age_q;
    end else begin
      ring_d = ring_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      ring_q <= '0;
    end else begin
      tok_q  <= tok_d;
      ring_q <= ring_d;
    end
  end

  assign tok_o  = tok_q;
  assign ring_o = ring_q;
  assign hit_o  = ring_q.valid && valid_q && (ring_q.age == age_q);

endmodule

### hdl/ofis_ctrl.sv
// request sequencer: policy register, way/settle counters, duplicate
// accumulation and the result register; uses ofis_pkg and the macro header
`include "oldest_first_issue_select_top_defines.svh"
module ofis_ctrl
  import ofis_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [3:0]         slot_i,
  input  logic               entry_valid_i,
  input  logic [31:0]        age_i,
  input  logic [15:0]        payload_i,
  input  logic               src_one_ready_i,
  input  logic               src_two_ready_i,
  input  logic [1:0]         way_busy_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               policy_mode_i,
  input  ofis_tok_t          tok_i,
  input  logic [ENTRIES-1:0] hit_i,
  output ofis_cell_ctl_t     cell_ctl_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               way_o,
  output logic               granted_o,
  output logic [3:0]         picked_slot_o,
  output logic [31:0]        picked_age_o,
  output logic [15:0]        picked_payload_o,
  output logic               duplicate_error_o,
  output logic               last_o
);

  ofis_state_e          state_q, state_d;
  ofis_policy_e         policy_q;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [WAY_BITS-1:0]  way_q, way_d;
  logic [1:0]           busy_q;
  logic                 dup_q, dup_d;

  logic                 out_valid_q;
  logic                 out_way_q;
  logic                 out_granted_q;
  logic [3:0]           out_slot_q;
  logic [31:0]          out_age_q;
  logic [15:0]          out_payload_q;
  logic                 out_dup_q;
  logic                 out_last_q;

  logic in_accept;
  logic sched_req;
  logic settled;
  logic load;
  logic way_is_busy;
  logic grant;
  logic is_last;
  logic cmp_en;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign sched_req   = in_accept && (ofis_cmd_e'(cmd_i) == CMD_SCHED);

  // the chain output is good once the wave has crossed every cell
  assign settled     = (state_q == ST_SEARCH) && (cnt_q == CNT_BITS'(ENTRIES));
  assign load        = settled && (!out_valid_q || !out_stall_i);
  // ways past the busy field count as free
  assign way_is_busy = (way_q <= WAY_BITS'(1)) && busy_q[way_q[0]];
  assign grant       = !way_is_busy && tok_i.found &&
                       ((policy_q == POLICY_OOO) || tok_i.rdy_ok);
  assign is_last     = (way_q == WAY_BITS'(WAYS - 1));
  // ring comparisons are meaningful for rotations 1 .. ENTRIES-1 of way 0
  assign cmp_en      = (state_q == ST_SEARCH) && (way_q == '0) &&
                       (cnt_q != '0) && (cnt_q < CNT_BITS'(ENTRIES));

  always_comb begin
    cell_ctl_o.wr_en      = in_accept && (ofis_cmd_e'(cmd_i) == CMD_WRITE) &&
                            (32'(slot_i) < ENTRIES);
    cell_ctl_o.wr_slot    = SLOT_BITS'(slot_i);
    cell_ctl_o.wr_valid   = entry_valid_i;
    cell_ctl_o.wr_age     = AGE_BITS'(age_i);
    cell_ctl_o.wr_payload = PAYLOAD_BITS'(payload_i);
    cell_ctl_o.wr_rdy     = {src_two_ready_i, src_one_ready_i};
    cell_ctl_o.mark_en    = load && grant;
    cell_ctl_o.mark_slot  = tok_i.slot;
    cell_ctl_o.ooo        = (policy_q == POLICY_OOO);
    cell_ctl_o.ring_load  = sched_req;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    way_d   = way_q;
    dup_d   = dup_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sched_req) begin
          state_d = ST_SEARCH;
          cnt_d   = '0;
          way_d   = '0;
          dup_d   = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (cmp_en && (|hit_i)) begin
          dup_d = 1'b1;
        end
        if (load) begin
          cnt_d = '0;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            way_d = way_q + WAY_BITS'(1);
          end
        end else if (!settled) begin
          cnt_d = cnt_q + CNT_BITS'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= POLICY_IN_ORDER;
      cnt_q       <= '0;
      way_q       <= '0;
      busy_q      <= 2'b00;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      way_q   <= way_d;
      dup_q   <= dup_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= ofis_policy_e'(policy_mode_i);
      end
      if (sched_req) begin
        busy_q <= way_busy_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_way_q     <= way_q[0];
      out_granted_q <= grant;
      out_slot_q    <= grant ? 4'(tok_i.slot) : 4'd0;
      out_age_q     <= grant ? 32'(tok_i.age) : 32'd0;
      out_payload_q <= grant ? 16'(tok_i.payload) : 16'd0;
      out_dup_q     <= dup_q;
      out_last_q    <= is_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign way_o             = out_way_q;
  assign granted_o         = out_granted_q;
  assign picked_slot_o     = out_slot_q;
  assign picked_age_o      = out_age_q;
  assign picked_payload_o  = out_payload_q;
  assign duplicate_error_o = out_dup_q;
  assign last_o            = out_last_q;

  `OFIS_ASSERT_NXT(a_sched_starts_way0, sched_req,
    (state_q == ST_SEARCH) && (way_q == '0) && (cnt_q == '0),
    "schedule request did not start at way 0")
  `OFIS_ASSERT_NXT(a_last_returns_idle, load && is_last,
    (state_q == ST_IDLE) && out_valid_q && out_last_q,
    "final result did not end the request")
  `OFIS_ASSERT_IMP(a_way_in_range, state_q == ST_SEARCH,
    way_q <= WAY_BITS'(WAYS - 1),
    "way counter ran past the last way")
  `OFIS_ASSERT_IMP(a_idle_result_zero, out_valid_q && !out_granted_q,
    (out_slot_q == 4'd0) && (out_age_q == 32'd0) && (out_payload_q == 16'd0),
    "empty grant carries nonzero fields")
  `OFIS_ASSERT_NXT(a_dup_held, (state_q == ST_SEARCH) && (way_q != '0),
    (dup_q == $past(dup_q)) || (state_q == ST_IDLE) || $past(sched_req),
    "duplicate flag changed after way 0")

endmodule

### hdl/oldest_first_issue_select_top.sv
// top level of the oldest-first issue select: row of entry cells plus sequencer
// uses ofis_pkg, ofis_cell and ofis_ctrl
//
//  channel | handshake               | carries
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | cmd, slot, entry fields, way_busy
//  out     | out_valid_o/out_stall_i | way, granted, picked_*, dup flag, last
//  cfg     | cfg_valid_i/cfg_ready_o | policy_mode
//
// a write request is taken while idle; a schedule request searches the ways in
// turn: for each way the search wave crosses the row one cell per clock before
// the pick is known. reset clears valid, scheduled and ready bits, the policy
// and the sequencer; stored ages and payloads are not cleared. a stalled output
// holds the search at the end of the current way; the last result may wait
// while new requests are taken.
module oldest_first_issue_select_top
  import ofis_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  slot_i,
  input  logic        entry_valid_i,
  input  logic [31:0] age_i,
  input  logic [15:0] payload_i,
  input  logic        src_one_ready_i,
  input  logic        src_two_ready_i,
  input  logic [1:0]  way_busy_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        policy_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        way_o,
  output logic        granted_o,
  output logic [3:0]  picked_slot_o,
  output logic [31:0] picked_age_o,
  output logic [15:0] picked_payload_o,
  output logic        duplicate_error_o,
  output logic        last_o
);

  ofis_cell_ctl_t     cell_ctl;
  ofis_tok_t          tok   [ENTRIES+1];
  ofis_ring_t         ring  [ENTRIES];
  logic [ENTRIES-1:0] hit;

  // chain head: no candidate yet
  assign tok[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ofis_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (SLOT_BITS'(i)),
      .ctl_i      (cell_ctl),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .ring_i     (ring[(i + ENTRIES - 1) % ENTRIES]),
      .ring_o     (ring[i]),
      .hit_o      (hit[i])
    );
  end

  ofis_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .slot_i            (slot_i),
    .entry_valid_i     (entry_valid_i),
    .age_i             (age_i),
    .payload_i         (payload_i),
    .src_one_ready_i   (src_one_ready_i),
    .src_two_ready_i   (src_two_ready_i),
    .way_busy_i        (way_busy_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .policy_mode_i     (policy_mode_i),
    .tok_i             (tok[ENTRIES]),
    .hit_i             (hit),
    .cell_ctl_o        (cell_ctl),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .way_o             (way_o),
    .granted_o         (granted_o),
    .picked_slot_o     (picked_slot_o),
    .picked_age_o      (picked_age_o),
    .picked_payload_o  (picked_payload_o),
    .duplicate_error_o (duplicate_error_o),
    .last_o            (last_o)
  );

endmodule
